FILE: rtl/hpt_pkg.sv
// Handle pointer table: shared constants, codes and controller/datapath structs.
// No dependencies; compiled first.
package hpt_pkg;

    localparam int OPC_BITS  = 3;
    localparam int HDL_BITS  = 32;
    localparam int PTR_BITS  = 64;
    localparam int STAT_BITS = 3;
    localparam int CFG_BITS  = 11;

    localparam int DEF_TABLE_DEPTH  = 1024;
    localparam int DEF_POINTER_BITS = 64;

    localparam logic [CFG_BITS-1:0] CFG_RESET   = 11'd1024;
    localparam logic [HDL_BITS-1:0] NULL_HANDLE = '1;

    localparam logic [OPC_BITS-1:0] OP_REGISTER = 3'd0;
    localparam logic [OPC_BITS-1:0] OP_FIND     = 3'd1;
    localparam logic [OPC_BITS-1:0] OP_GET      = 3'd2;
    localparam logic [OPC_BITS-1:0] OP_SET      = 3'd3;
    localparam logic [OPC_BITS-1:0] OP_CLEAR    = 3'd4;

    localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_FAULTY   = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_INUSE    = 3'd4;

    typedef struct packed {
        logic wipe;
        logic start;
        logic scan;
        logic rd_hdl;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic wipe_last;
        logic to_scan;
        logic to_read;
        logic scan_done;
    } t_dp_stat;

endpackage

FILE: rtl/hpt_if.sv
// Handle pointer table: valid/ready channel interfaces for request and result words.
// Depends on hpt_pkg.
interface hpt_in_if import hpt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPC_BITS-1:0] opcode;
    logic [PTR_BITS-1:0] pointer_value;
    logic [HDL_BITS-1:0] handle_in;

    modport source (output valid, output opcode, output pointer_value, output handle_in,
                    input ready);
    modport sink   (input valid, input opcode, input pointer_value, input handle_in,
                    output ready);
endinterface

interface hpt_out_if import hpt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HDL_BITS-1:0]  handle_out;
    logic [PTR_BITS-1:0]  pointer_out;
    logic [STAT_BITS-1:0] status;

    modport source (output valid, output handle_out, output pointer_out, output status,
                    input ready);
    modport sink   (input valid, input handle_out, input pointer_out, input status,
                    output ready);
endinterface

FILE: rtl/hpt_ram.sv
// Handle pointer table: generic single-write, single-read RAM with registered read.
// No dependencies.
module hpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hpt_datapath.sv
// Handle pointer table datapath: config register, high-water mark, scan pipeline,
// table RAM and result registers. Depends on hpt_pkg and hpt_ram.
module hpt_datapath import hpt_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int POINTER_BITS = DEF_POINTER_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,
    input  logic [OPC_BITS-1:0]  i_opcode,
    input  logic [PTR_BITS-1:0]  i_pointer_value,
    input  logic [HDL_BITS-1:0]  i_handle_in,
    output logic [HDL_BITS-1:0]  o_handle_out,
    output logic [PTR_BITS-1:0]  o_pointer_out,
    output logic [STAT_BITS-1:0] o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = ($clog2(TABLE_DEPTH + 1) > CFG_BITS) ? $clog2(TABLE_DEPTH + 1)
                                                              : CFG_BITS;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

    logic [CFG_BITS-1:0]     r_cfg;
    logic [LW-1:0]           r_mark, n_mark;
    logic [OPC_BITS-1:0]     r_op;
    logic [POINTER_BITS-1:0] r_val;
    logic [HDL_BITS-1:0]     r_hdl;
    logic [LW-1:0]           r_rd_addr, r_cmp_ix, r_hit_ix, r_free;
    logic                    r_cmp_vld, r_found;
    logic [AW-1:0]           r_wipe_ix;
    logic [HDL_BITS-1:0]     r_hout, n_hout;
    logic [PTR_BITS-1:0]     r_pout, n_pout;
    logic [STAT_BITS-1:0]    r_stat, n_stat;

    logic [LW-1:0]           w_cfg_l, w_s, w_lim;
    logic                    w_h_null, w_h_zero, w_h_oob, w_val_zero;
    logic [AW-1:0]           w_hix;
    logic                    w_issue, w_hit, w_empty;
    logic                    w_re, w_we;
    logic [AW-1:0]           w_raddr, w_waddr;
    logic [POINTER_BITS-1:0] w_wdata, w_q;

    // usable entries S and scan limit L = min(mark, S)
    assign w_cfg_l = LW'(r_cfg);
    assign w_s     = (w_cfg_l > DEPTH_L) ? DEPTH_L : w_cfg_l;
    assign w_lim   = (r_mark < w_s) ? r_mark : w_s;

    assign w_h_null   = (r_hdl == NULL_HANDLE);
    assign w_h_zero   = (r_hdl == '0);
    assign w_h_oob    = (r_hdl >= HDL_BITS'(w_s));
    assign w_hix      = r_hdl[AW-1:0];
    assign w_val_zero = (r_val == '0);

    // scan: address stage issues reads, compare stage checks the returned entry
    assign w_issue = i_cmd.scan && !r_found && (r_rd_addr < w_lim);
    assign w_hit   = i_cmd.scan && r_cmp_vld && !r_found && (w_q == r_val);
    assign w_empty = i_cmd.scan && r_cmp_vld && !r_found && (w_q == '0);

    assign o_stat.wipe_last = (r_wipe_ix == AW'(TABLE_DEPTH - 1));
    assign o_stat.to_scan   = ((r_op == OP_REGISTER) && !w_val_zero) || (r_op == OP_FIND);
    assign o_stat.to_read   = (((r_op == OP_GET) || (r_op == OP_SET))
                                  && !w_h_zero && !w_h_null && !w_h_oob)
                            || ((r_op == OP_CLEAR) && !w_h_null && !w_h_oob);
    assign o_stat.scan_done = r_found || (!r_cmp_vld && (r_rd_addr >= w_lim));

    assign w_re    = w_issue || i_cmd.rd_hdl;
    assign w_raddr = i_cmd.rd_hdl ? w_hix : r_rd_addr[AW-1:0];

    always_comb begin
        n_hout  = '0;
        n_pout  = '0;
        n_stat  = ST_OK;
        n_mark  = r_mark;
        w_we    = 1'b0;
        w_waddr = w_hix;
        w_wdata = '0;
        unique case (r_op)
            OP_REGISTER: begin
                priority if (w_val_zero) begin
                    n_hout = NULL_HANDLE;
                end else if (r_found) begin
                    n_hout = HDL_BITS'(r_hit_ix);
                end else if (r_free != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_free[AW-1:0];
                    w_wdata = r_val;
                    n_hout  = HDL_BITS'(r_free);
                end else if (w_lim < w_s) begin
                    // append at the mark
                    w_we    = 1'b1;
                    w_waddr = w_lim[AW-1:0];
                    w_wdata = r_val;
                    n_hout  = HDL_BITS'(w_lim);
                    n_mark  = w_lim + LW'(1);
                end else begin
                    n_stat = ST_NOSPACE;
                end
            end
            OP_FIND: begin
                if (r_found) begin
                    n_hout = HDL_BITS'(r_hit_ix);
                end else begin
                    n_stat = ST_NOTFOUND;
                end
            end
            OP_GET: begin
                priority if (w_h_zero || w_h_null) begin
                    n_pout = '0;
                end else if (w_h_oob) begin
                    n_stat = ST_FAULTY;
                end else begin
                    n_pout = PTR_BITS'(w_q);
                end
            end
            OP_SET: begin
                priority if (w_h_zero || w_h_null || w_h_oob) begin
                    n_stat = ST_FAULTY;
                end else if ((w_q == '0) || (w_q == r_val)) begin
                    w_we    = 1'b1;
                    w_wdata = r_val;
                end else begin
                    n_stat = ST_INUSE;
                end
            end
            OP_CLEAR: begin
                priority if (w_h_null) begin
                    n_pout = '0;
                end else if (w_h_oob) begin
                    n_stat = ST_FAULTY;
                end else begin
                    n_pout = PTR_BITS'(w_q);
                    w_we   = 1'b1;
                end
            end
            default: begin
                n_stat = ST_OK;
            end
        endcase
        if (i_cmd.wipe) begin
            w_we    = 1'b1;
            w_waddr = r_wipe_ix;
            w_wdata = '0;
        end else if (!i_cmd.finish) begin
            w_we = 1'b0;
        end
    end

    hpt_ram #(
        .WIDTH (POINTER_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RESET;
            r_mark    <= LW'(1);
            r_wipe_ix <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free    <= '0;
            r_hit_ix  <= '0;
            r_cmp_ix  <= '0;
            r_rd_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.wipe) begin
                r_wipe_ix <= r_wipe_ix + AW'(1);
            end
            if (i_cmd.finish) begin
                r_mark <= n_mark;
            end
            if (i_cmd.start) begin
                r_found   <= 1'b0;
                r_free    <= '0;
                r_cmp_vld <= 1'b0;
                // find covers entry 0, register starts at 1
                r_rd_addr <= (i_opcode == OP_FIND) ? LW'(0) : LW'(1);
            end else begin
                r_cmp_vld <= w_issue;
                if (w_issue) begin
                    r_cmp_ix  <= r_rd_addr;
                    r_rd_addr <= r_rd_addr + LW'(1);
                end
                if (w_hit) begin
                    r_found  <= 1'b1;
                    r_hit_ix <= r_cmp_ix;
                end else if (w_empty) begin
                    r_free <= r_cmp_ix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_opcode;
            r_val <= i_pointer_value[POINTER_BITS-1:0];
            r_hdl <= i_handle_in;
        end
        if (i_cmd.finish) begin
            r_hout <= n_hout;
            r_pout <= n_pout;
            r_stat <= n_stat;
        end
    end

    assign o_handle_out  = r_hout;
    assign o_pointer_out = r_pout;
    assign o_status      = r_stat;

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mark != '0) && (r_mark <= DEPTH_L))
        else $error("high-water mark out of range");

    a_hit_below_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_hit_ix < r_mark))
        else $error("match index at or above mark");

    a_cmp_below_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> ((r_cmp_ix < r_mark) && (r_free < r_mark)))
        else $error("scan index at or above mark");

endmodule

FILE: rtl/hpt_ctrl.sv
// Handle pointer table controller: sequences wipe, decode, scan, read and result.
// Depends on hpt_pkg; drives hpt_datapath through t_dp_cmd.
module hpt_ctrl import hpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.to_scan) begin
                    n_state = S_SCAN;
                end else if (i_stat.to_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.rd_hdl = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_WIPE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/handle_pointer_table.sv
// Handle pointer table top level: valid/ready request and result words, one config register.
// Register and find scan the entries below L (L = min(mark, usable)) one per cycle through
// the table RAM read port, stopping at a match; register starts at entry 1. One word is in
// work at a time; the result register lets a new word in while it waits. Reset is
// synchronous, active low; afterwards the RAM is zeroed entry by entry with ready low.
// Depends on hpt_pkg, hpt_if, hpt_ctrl, hpt_datapath.
module handle_pointer_table import hpt_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int POINTER_BITS = DEF_POINTER_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hpt_in_if.sink              i_in,
    hpt_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    hpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    hpt_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .POINTER_BITS (POINTER_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_in.opcode),
        .i_pointer_value (i_in.pointer_value),
        .i_handle_in     (i_in.handle_in),
        .o_handle_out    (o_out.handle_out),
        .o_pointer_out   (o_out.pointer_out),
        .o_status        (o_out.status)
    );

endmodule
